@@ src/mhpq_pkg.sv @@
// Package for the binary max-heap priority queue.
// Holds the record, transaction and status types and the state encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  // Field widths fixed by the interface
  localparam int CAP_W = 7;
  localparam int OCC_W = 7;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_UP,
    FSM_PLACE,
    FSM_LOAD,
    FSM_DOWN,
    FSM_DONE
  } fsm_t;

  // One heap entry as held in the store
  typedef struct packed {
    logic        [31:0] tag;
    logic        [7:0]  kind;
    logic signed [31:0] key;
    logic signed [31:0] est_time;
    logic signed [31:0] prio;
  } rec_t;

  typedef struct packed {
    logic               command;
    logic        [31:0] task_tag;
    logic        [7:0]  task_kind;
    logic signed [31:0] energy_key;
    logic signed [31:0] estimated_time;
    logic signed [31:0] task_priority;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic        [31:0] out_tag;
    logic        [7:0]  out_kind;
    logic signed [31:0] out_energy;
    logic signed [31:0] out_time;
    logic signed [31:0] out_priority;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

endpackage

`default_nettype wire

@@ src/mhpq_store.sv @@
// Heap entry store: one write port, two registered read ports.
// Depends on mhpq_pkg for the entry record type.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  mhpq_pkg::rec_t  wr_data,
  input  logic [AW-1:0]   rd_a_addr,
  input  logic [AW-1:0]   rd_b_addr,
  output mhpq_pkg::rec_t  rd_a_data,
  output mhpq_pkg::rec_t  rd_b_data
);
  import mhpq_pkg::*;

  rec_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports; old data on a same-address write
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

@@ src/max_heap_priority_queue.sv @@
// Binary max-heap priority queue, top level: sequencer, count and result register.
// Depends on mhpq_pkg and mhpq_store.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | in_item_t  (command and record)
//  out_    | output    | out_valid / out_stall  | out_item_t (status, root, occupancy)
//  cfg_    | input     | cfg_valid / cfg_ready  | active capacity, 7 bits
//
// One transaction at a time. Insert climbs level by level toward the root (an empty heap
// is written directly); remove loads the root and last entry, then sinks the last entry
// level by level (not when it empties the heap); a refused command goes to FSM_DONE.
// Each level reads the parent or both children from the store, compares, writes back.
// Synchronous reset clears the count and sets capacity to 64; the store is not cleared.
// A finished result waits in its register while out_stall is high; a further result
// waits in the sequencer, which then holds in_stall high.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mhpq_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mhpq_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mhpq_pkg::CAP_W-1:0]    cfg_data
);
  import mhpq_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int CW   = AW + 2;
  localparam int CMPW = (CNTW > CAP_W) ? CNTW : CAP_W;

  fsm_t             state_r, state_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [AW-1:0]    pos_r, pos_nxt;
  rec_t             item_r, item_nxt;
  out_item_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  rec_t             wr_data;
  logic [AW-1:0]    rd_a_addr;
  logic [AW-1:0]    rd_b_addr;
  rec_t             rd_a_data;
  rec_t             rd_b_data;

  rec_t             in_rec;
  logic             ins_room;
  logic [AW-1:0]    par_idx;
  logic [CW-1:0]    lc_idx;
  logic [CW-1:0]    rc_idx;
  logic             l_ok;
  logic             r_ok;
  logic             take_l;
  logic             take_r;
  logic signed [31:0] best_key;
  logic [AW-1:0]    child_pos;
  logic [AW:0]      gl_idx;
  logic [AW:0]      gr_idx;

  mhpq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  // Incoming record
  always_comb begin
    in_rec.tag      = in_data.task_tag;
    in_rec.kind     = in_data.task_kind;
    in_rec.key      = in_data.energy_key;
    in_rec.est_time = in_data.estimated_time;
    in_rec.prio     = in_data.task_priority;
  end

  // Room for an insert: below both the configured capacity and the store depth
  assign ins_room = (CMPW'(count_r) < CMPW'(cap_r)) && (count_r < CNTW'(DEPTH));

  // Index arithmetic for the two sift directions
  assign par_idx = AW'((pos_r - 1'b1) >> 1);
  assign lc_idx  = {1'b0, pos_r, 1'b1};
  assign rc_idx  = lc_idx + 1'b1;
  assign l_ok    = lc_idx < CW'(count_r);
  assign r_ok    = rc_idx < CW'(count_r);

  // Child selection: strict compares, left child wins ties
  assign take_l    = l_ok && ($signed(rd_a_data.key) > $signed(item_r.key));
  assign best_key  = take_l ? rd_a_data.key : item_r.key;
  assign take_r    = r_ok && ($signed(rd_b_data.key) > $signed(best_key));
  assign child_pos = take_r ? AW'(rc_idx) : AW'(lc_idx);
  assign gl_idx    = {child_pos, 1'b1};
  assign gr_idx    = gl_idx + 1'b1;

  // Sequencer: next state, store accesses and result assembly
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = item_r;
    rd_a_addr     = '0;
    rd_b_addr     = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      FSM_IDLE: begin
        if (in_valid) begin
          res_nxt           = '0;
          res_nxt.status    = STAT_OK;
          res_nxt.occupancy = OCC_W'(count_r);
          if (in_data.command == CMD_INSERT) begin
            if (ins_room) begin
              item_nxt          = in_rec;
              pos_nxt           = AW'(count_r);
              count_nxt         = count_r + 1'b1;
              res_nxt.occupancy = OCC_W'(count_r + 1'b1);
              if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = in_rec;
                state_nxt = FSM_DONE;
              end else begin
                rd_a_addr = AW'((count_r - 1'b1) >> 1);
                state_nxt = FSM_UP;
              end
            end else begin
              res_nxt.status = STAT_FULL;
              state_nxt      = FSM_DONE;
            end
          end else begin
            if (count_r != '0) begin
              rd_a_addr         = '0;
              rd_b_addr         = AW'(count_r - 1'b1);
              count_nxt         = count_r - 1'b1;
              res_nxt.occupancy = OCC_W'(count_r - 1'b1);
              state_nxt         = FSM_LOAD;
            end else begin
              res_nxt.status = STAT_EMPTY;
              state_nxt      = FSM_DONE;
            end
          end
        end
      end

      // Parent data arrives; move it down into the hole or settle the item
      FSM_UP: begin
        wr_en = 1'b1;
        if ($signed(item_r.key) > $signed(rd_a_data.key)) begin
          wr_data = rd_a_data;
          pos_nxt = par_idx;
          if (par_idx == '0) begin
            state_nxt = FSM_PLACE;
          end else begin
            rd_a_addr = AW'((par_idx - 1'b1) >> 1);
          end
        end else begin
          state_nxt = FSM_DONE;
        end
      end

      // Item has climbed to the root
      FSM_PLACE: begin
        wr_en     = 1'b1;
        state_nxt = FSM_DONE;
      end

      // Root and last entry arrive; last becomes the sinking item
      FSM_LOAD: begin
        res_nxt.out_tag      = rd_a_data.tag;
        res_nxt.out_kind     = rd_a_data.kind;
        res_nxt.out_energy   = rd_a_data.key;
        res_nxt.out_time     = rd_a_data.est_time;
        res_nxt.out_priority = rd_a_data.prio;
        item_nxt             = rd_b_data;
        pos_nxt              = '0;
        if (count_r == '0) begin
          state_nxt = FSM_DONE;
        end else begin
          rd_a_addr = AW'(1);
          rd_b_addr = AW'(2);
          state_nxt = FSM_DOWN;
        end
      end

      // Children arrive; lift the larger one into the hole or settle the item
      FSM_DOWN: begin
        wr_en = 1'b1;
        if (take_l || take_r) begin
          wr_data   = take_r ? rd_b_data : rd_a_data;
          pos_nxt   = child_pos;
          rd_a_addr = AW'(gl_idx);
          rd_b_addr = AW'(gr_idx);
        end else begin
          state_nxt = FSM_DONE;
        end
      end

      // Hand the result to the output register once it is free
      FSM_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = FSM_IDLE;
        end
      end

      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != FSM_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ src/mhpq_checker.sv @@
// Port-level checks for the heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire mhpq_pkg::in_item_t         in_data,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire mhpq_pkg::out_item_t        out_data,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [mhpq_pkg::CAP_W-1:0] cfg_data
);
  import mhpq_pkg::*;

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One transaction at a time: an accepted item closes the input next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // Refused operations carry no record
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |->
      (out_data.out_tag == '0) && (out_data.out_kind == '0) &&
      (out_data.out_energy == '0) && (out_data.out_time == '0) &&
      (out_data.out_priority == '0))
    else $error("refused operation returned a record");

  // An empty refusal only happens with nothing stored
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_EMPTY) |-> (out_data.occupancy == '0))
    else $error("empty status with entries present");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

`default_nettype wire
